// File: src/avcd_pkg.sv
// ----------------------------------------------------------------------------
// AVI video chunk deframer package
// Beat types, phase codes and register map shared by the deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package avcd_pkg;

    // one byte of the movie chunk stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_beat;

    // one result per input byte
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_start;
        logic [31:0] frame_len;
        logic        frame_last;
        logic        stream_end;
        logic [15:0] frame_number;
    } t_out_beat;

    // parser phase codes (code 3 is never entered; it acts as ended)
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_ENDED   = 2'd2;

    // header byte positions
    localparam logic [2:0] POS_TAG_FIRST  = 3'd0;
    localparam logic [2:0] POS_TAG_LAST   = 3'd3;
    localparam logic [2:0] POS_SIZE_FIRST = 3'd4;
    localparam logic [2:0] POS_SIZE_LAST  = 3'd7;

    // register map
    localparam int          ADDR_W         = 3;
    localparam logic        REG_VIDEO_TAG  = 1'b0;
    localparam logic [31:0] VIDEO_TAG_RST  = 32'h6364_3030;   // "00dc"

endpackage : avcd_pkg

`default_nettype wire

// File: src/avcd_parse.sv
// ----------------------------------------------------------------------------
// AVI video chunk deframer: parse stage
// Holds the header/payload state and works out the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module avcd_parse
    import avcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_in_beat    i_beat,
    input  wire logic [31:0] i_video_tag,
    output t_out_beat        o_result
);

    logic [1:0]  r_phase,  n_phase;
    logic [2:0]  r_pos,    n_pos;
    logic [31:0] r_tag,    n_tag;
    logic [31:0] r_size,   n_size;
    logic [31:0] r_remain, n_remain;
    logic [15:0] r_frames, n_frames;

    logic [1:0]  cur_phase;
    logic [2:0]  cur_pos;
    logic [31:0] cur_tag;
    logic [31:0] cur_size;
    logic [31:0] cur_remain;
    logic [15:0] cur_frames;
    logic [31:0] byte_ext;
    logic [4:0]  byte_shift;

    assign byte_ext   = {24'd0, i_beat.data_byte};
    assign byte_shift = {cur_pos[1:0], 3'd0};

    always_comb begin
        // restart clears everything before the byte is used
        if (i_beat.restart) begin
            cur_phase  = PH_HEADER;
            cur_pos    = POS_TAG_FIRST;
            cur_tag    = '0;
            cur_size   = '0;
            cur_remain = '0;
            cur_frames = '0;
        end else begin
            cur_phase  = r_phase;
            cur_pos    = r_pos;
            cur_tag    = r_tag;
            cur_size   = r_size;
            cur_remain = r_remain;
            cur_frames = r_frames;
        end

        n_phase  = cur_phase;
        n_pos    = cur_pos;
        n_tag    = cur_tag;
        n_size   = cur_size;
        n_remain = cur_remain;
        n_frames = cur_frames;
        o_result = '0;

        case (cur_phase)
            PH_HEADER: begin
                if (!cur_pos[2]) begin
                    n_tag = (cur_pos == POS_TAG_FIRST) ? byte_ext
                                                       : (cur_tag | (byte_ext << byte_shift));
                    if (cur_pos == POS_TAG_LAST && n_tag != i_video_tag) begin
                        o_result.stream_end = 1'b1;
                        n_phase = PH_ENDED;
                        n_pos   = POS_TAG_FIRST;
                    end else begin
                        n_pos = cur_pos + 3'd1;
                    end
                end else begin
                    n_size = (cur_pos == POS_SIZE_FIRST) ? byte_ext
                                                         : (cur_size | (byte_ext << byte_shift));
                    if (cur_pos == POS_SIZE_LAST) begin
                        o_result.frame_start = 1'b1;
                        o_result.frame_len   = n_size;
                        n_frames = cur_frames + 16'd1;
                        n_pos    = POS_TAG_FIRST;
                        // zero size: frame start only, stay in header phase
                        if (n_size != 32'd0) begin
                            n_remain = n_size;
                            n_phase  = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = cur_pos + 3'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_result.payload_byte  = i_beat.data_byte;
                o_result.payload_valid = 1'b1;
                if (cur_remain != 32'd0) begin
                    n_remain = cur_remain - 32'd1;
                end
                if (n_remain == 32'd0) begin
                    o_result.frame_last = 1'b1;
                    n_phase = PH_HEADER;
                    n_pos   = POS_TAG_FIRST;
                end
            end
            default: begin
                // ended: drop the byte
            end
        endcase

        o_result.frame_number = n_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= POS_TAG_FIRST;
            r_tag    <= '0;
            r_size   <= '0;
            r_remain <= '0;
            r_frames <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_tag    <= n_tag;
            r_size   <= n_size;
            r_remain <= n_remain;
            r_frames <= n_frames;
        end
    end

endmodule : avcd_parse

`default_nettype wire

// File: src/avi_video_chunk_deframer_top.sv
// ----------------------------------------------------------------------------
// AVI video chunk deframer
// Splits a movie chunk byte stream into video frames, one result per byte.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     i_in_beat  (t_in_beat)
//   out       output     o_out_valid / i_out_ready   o_out_beat (t_out_beat)
//   cfg       input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One byte per clock sustained while the sink keeps up. A byte is registered,
// parsed from the input register and its result lands in the output register or skid.
// A two-entry output buffer (output register plus skid) keeps input flowing
// while a result waits; a stalled sink fills the skid and then holds off input.
// Synchronous active-low reset clears parser state and restores video_tag.
// ----------------------------------------------------------------------------
`default_nettype none

module avi_video_chunk_deframer_top
    import avcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // byte stream in
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_beat          i_in_beat,
    // results out
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_beat              o_out_beat,
    // config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [31:0] r_video_tag;
    logic        cfg_wr;
    logic        tag_sel;

    logic        r_in_valid;
    t_in_beat    r_in_beat;
    logic        step;
    t_out_beat   parse_result;

    logic        r_out_valid;
    t_out_beat   r_out_beat;
    logic        r_skid_valid;
    t_out_beat   r_skid_beat;
    logic        out_pop;

    // ---- config port ----
    assign pready  = 1'b1;
    assign tag_sel = (paddr[ADDR_W-1] == REG_VIDEO_TAG);
    assign cfg_wr  = psel && penable && pwrite && tag_sel;
    assign prdata  = tag_sel ? r_video_tag : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_tag <= VIDEO_TAG_RST;
        end else if (cfg_wr) begin
            r_video_tag <= pwdata;
        end
    end

    // ---- input register ----
    // parse only when the skid slot is free, so a result always has a home
    assign step       = r_in_valid && !r_skid_valid;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    avcd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_beat      (r_in_beat),
        .i_video_tag (r_video_tag),
        .o_result    (parse_result)
    );

    // ---- output register + skid ----
    assign out_pop     = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || step;
            r_skid_valid <= 1'b0;
        end else if (step) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop || !r_out_valid) begin
            r_out_beat <= r_skid_valid ? r_skid_beat : parse_result;
        end else if (step) begin
            r_skid_beat <= parse_result;
        end
    end

endmodule : avi_video_chunk_deframer_top

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// AVI video chunk deframer testbench
// Feeds movie chunk byte streams through the deframer under random source and
// sink idling. Each accepted byte is run through an in-bench parser model and
// every output beat is checked field by field in order. The video tag register
// is rewritten between phases. The run finishes with a stretch that has no
// idling on either side.
// ----------------------------------------------------------------------------

module testbench;
    import avcd_pkg::*;

    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [31:0] IDX1_TAG       = 32'h3178_6469;   // "idx1"
    localparam logic [ADDR_W-1:0] ADDR_VIDEO_TAG = ADDR_W'(4 * REG_VIDEO_TAG);

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_vld   = 1'b0;
    t_in_beat          in_beat  = '0;
    logic              in_rdy;
    logic              out_vld;
    logic              out_rdy  = 1'b0;
    t_out_beat         out_beat;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // stimulus and scoreboard
    t_in_beat  pending_bytes[$];
    t_out_beat expected_beats[$];
    int        bytes_queued = 0;
    int        bytes_taken  = 0;
    int        beats_seen   = 0;
    int        n_errors     = 0;
    bit        restart_due  = 1'b1;
    bit        quiet_tail   = 1'b0;
    int        send_gap     = 0;
    int        sink_gap     = 0;
    int        hold_left    = 0;
    int        hold_seen    = 0;

    // parser model state
    logic [1:0]  mdl_phase;
    logic [2:0]  mdl_pos;
    logic [31:0] mdl_tag;
    logic [31:0] mdl_size;
    logic [31:0] mdl_left;
    logic [15:0] mdl_frames;
    logic [31:0] mdl_video_tag = VIDEO_TAG_RST;

    wire in_fire  = in_vld && in_rdy;
    wire out_fire = out_vld && out_rdy;

    avi_video_chunk_deframer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_vld),
        .o_in_ready  (in_rdy),
        .i_in_beat   (in_beat),
        .o_out_valid (out_vld),
        .i_out_ready (out_rdy),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ---- parser model: one result beat per byte ----
    function automatic t_out_beat deframe_byte(t_in_beat b);
        t_out_beat r;
        r = '0;
        if (b.restart) begin
            mdl_phase  = PH_HEADER;
            mdl_pos    = POS_TAG_FIRST;
            mdl_tag    = '0;
            mdl_size   = '0;
            mdl_left   = '0;
            mdl_frames = '0;
        end
        case (mdl_phase)
            PH_HEADER: begin
                if (mdl_pos <= POS_TAG_LAST) begin
                    if (mdl_pos == POS_TAG_FIRST)
                        mdl_tag = {24'd0, b.data_byte};
                    else
                        mdl_tag[8*mdl_pos +: 8] = b.data_byte;
                    if (mdl_pos == POS_TAG_LAST && mdl_tag != mdl_video_tag) begin
                        r.stream_end = 1'b1;
                        mdl_phase    = PH_ENDED;
                        mdl_pos      = POS_TAG_FIRST;
                    end else begin
                        mdl_pos = mdl_pos + 3'd1;
                    end
                end else begin
                    if (mdl_pos == POS_SIZE_FIRST)
                        mdl_size = {24'd0, b.data_byte};
                    else
                        mdl_size[8*(mdl_pos - POS_SIZE_FIRST) +: 8] = b.data_byte;
                    if (mdl_pos == POS_SIZE_LAST) begin
                        r.frame_start = 1'b1;
                        r.frame_len   = mdl_size;
                        mdl_frames    = mdl_frames + 16'd1;
                        mdl_pos       = POS_TAG_FIRST;
                        if (mdl_size != 0) begin
                            mdl_left  = mdl_size;
                            mdl_phase = PH_PAYLOAD;
                        end
                    end else begin
                        mdl_pos = mdl_pos + 3'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.payload_byte  = b.data_byte;
                r.payload_valid = 1'b1;
                if (mdl_left != 0)
                    mdl_left = mdl_left - 32'd1;
                if (mdl_left == 0) begin
                    r.frame_last = 1'b1;
                    mdl_phase    = PH_HEADER;
                    mdl_pos      = POS_TAG_FIRST;
                end
            end
            default: ;  // ended: byte ignored until restart
        endcase
        r.frame_number = mdl_frames;
        return r;
    endfunction

    function automatic string beat_str(t_out_beat b);
        return $sformatf("pay=%02h pv=%0d fs=%0d size=%08h last=%0d end=%0d num=%0d",
                         b.payload_byte, b.payload_valid, b.frame_start, b.frame_len,
                         b.frame_last, b.stream_end, b.frame_number);
    endfunction

    // ---- stream building ----
    function automatic void push_byte(logic [7:0] d, logic rs);
        t_in_beat b;
        b.data_byte = d;
        b.restart   = rs;
        pending_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // little-endian word, restart flag only on the first byte
    function automatic void push_word(logic [31:0] w, logic rs);
        push_byte(w[7:0], rs);
        push_byte(w[15:8], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[31:24], 1'b0);
    endfunction

    task automatic add_stream(input int n_items, input logic [31:0] tag);
        int          made;
        int          kind;
        int          len;
        int          i;
        logic [31:0] size;
        logic [63:0] hdr;
        made        = 0;
        restart_due = 1'b1;
        while (made < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // well-formed frame, mostly short
                if ($urandom_range(0, 9) == 0)
                    size = $urandom_range(13, 40);
                else
                    size = $urandom_range(0, 12);
                push_word(tag, restart_due || ($urandom_range(0, 19) == 0));
                push_word(size, 1'b0);
                for (i = 0; i < size; i++)
                    push_byte(8'($urandom), 1'b0);
                made        += 8 + size;
                restart_due = 1'b0;
            end else if (kind < 78) begin
                // oversized frame cut off after 1 to 5 payload bytes
                if ($urandom_range(0, 2) == 0)
                    size = 32'hFFFF_FFFF;
                else
                    size = $urandom | 32'h40;
                push_word(tag, restart_due);
                push_word(size, 1'b0);
                len = $urandom_range(1, 5);
                repeat (len) push_byte(8'($urandom), 1'b0);
                made        += 8 + len;
                restart_due = 1'b1;
            end else if (kind < 86) begin
                // foreign tag ends the stream; trailing bytes are ignored
                push_word(tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3))),
                          restart_due);
                repeat ($urandom_range(0, 6)) push_byte(8'($urandom), 1'b0);
                made        += 4;
                restart_due = 1'b1;
            end else if (kind < 93) begin
                // header abandoned part way
                hdr = {32'($urandom), tag};
                len = $urandom_range(1, 7);
                for (i = 0; i < len; i++)
                    push_byte(hdr[8*i +: 8], (i == 0) ? restart_due : 1'b0);
                made        += len;
                restart_due = 1'b1;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) push_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                made        += len;
                restart_due = 1'b1;
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_video_tag(input logic [31:0] tag);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VIDEO_TAG;
        pwdata  <= tag;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        mdl_video_tag = tag;
    endtask

    // ---- source driver ----
    always @(posedge clk) begin
        if (!rst_n) begin
            in_vld   <= 1'b0;
            in_beat  <= '0;
            send_gap <= 0;
        end else if (!in_vld || in_rdy) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_vld   <= 1'b0;
            end else if (!quiet_tail && hold_left == 0 && $urandom_range(0, 6) == 0) begin
                send_gap <= $urandom_range(0, 8);
                in_vld   <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                in_vld  <= 1'b1;
                in_beat <= pending_bytes.pop_front();
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // ---- sink ready ----
    always @(posedge clk) begin
        if (!rst_n) begin
            out_rdy  <= 1'b0;
            sink_gap <= 0;
        end else if (hold_left != 0) begin
            out_rdy <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            out_rdy  <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            sink_gap <= $urandom_range(0, 8);
            out_rdy  <= 1'b0;
        end else begin
            out_rdy <= 1'b1;
        end
    end

    // long sink stall so the output buffer fills and input backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else begin
            if (in_fire)
                hold_seen <= hold_seen + 1;
            if (in_fire && (hold_seen == 40 || hold_seen == 200))
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // ---- monitor: predict on input beats, check output beats ----
    always @(posedge clk) begin : monitor
        t_out_beat want;
        if (!rst_n) begin
            mdl_phase  = PH_HEADER;
            mdl_pos    = POS_TAG_FIRST;
            mdl_tag    = '0;
            mdl_size   = '0;
            mdl_left   = '0;
            mdl_frames = '0;
        end else begin
            if (in_fire) begin
                expected_beats.push_back(deframe_byte(in_beat));
                bytes_taken++;
            end
            if (out_fire) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("beat %0d: unexpected, got %s", beats_seen, beat_str(out_beat));
                    n_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_beat.payload_byte  !== want.payload_byte  ||
                        out_beat.payload_valid !== want.payload_valid ||
                        out_beat.frame_start   !== want.frame_start   ||
                        out_beat.frame_len     !== want.frame_len     ||
                        out_beat.frame_last    !== want.frame_last    ||
                        out_beat.stream_end    !== want.stream_end    ||
                        out_beat.frame_number  !== want.frame_number) begin
                        if (n_errors < MAX_REPORTS)
                            $display("beat %0d: expected %s, got %s", beats_seen,
                                     beat_str(want), beat_str(out_beat));
                        n_errors++;
                    end
                end
            end
        end
    end

    // ---- test sequence ----
    initial begin : stim
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // zero-size frame, two-byte frame with extreme bytes, index chunk ends stream
        push_word(VIDEO_TAG_RST, 1'b1);
        push_word(32'd0, 1'b0);
        push_word(VIDEO_TAG_RST, 1'b0);
        push_word(32'd2, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_word(IDX1_TAG, 1'b0);
        push_byte(8'hFF, 1'b0);

        add_stream(110, VIDEO_TAG_RST);
        wait_drained();
        write_video_tag($urandom);
        add_stream(110, mdl_video_tag);
        wait_drained();
        write_video_tag(32'h0000_0000);
        add_stream(80, mdl_video_tag);
        wait_drained();
        write_video_tag(32'hFFFF_FFFF);
        add_stream(80, mdl_video_tag);
        wait_drained();
        write_video_tag(VIDEO_TAG_RST);

        quiet_tail = 1'b1;
        add_stream(30, VIDEO_TAG_RST);

        while (bytes_taken != bytes_queued || expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #(2 * HALF_PERIOD * 2_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/avcd_pkg.sv
src/avcd_parse.sv
src/avi_video_chunk_deframer_top.sv
dv/testbench.sv
